[design/ats_pkg.sv]
// Shared types and constants for the assembler token scanner.
// Holds the result record, the queue entry, the class codes and the keyword table.
// No dependencies.
package ats_pkg;

	localparam int MaxToken   = 256;
	localparam int NumKw      = 10;
	localparam int KwMaxLen   = 14;
	localparam int FifoDepth  = 4;
	localparam int PtrW       = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
	localparam int FifoCntW   = $clog2(FifoDepth + 1);
	localparam int LimCapInt  = (MaxToken - 1 > 255) ? 255 : MaxToken - 1;
	localparam logic [7:0] LimCap = 8'(LimCapInt);

	typedef enum logic [3:0] {
		ClsEof     = 4'd0,
		ClsTooBig  = 4'd1,
		ClsDec     = 4'd2,
		ClsHex     = 4'd3,
		ClsReal    = 4'd4,
		ClsIdent   = 4'd5,
		ClsLabel   = 4'd6,
		ClsLabDef  = 4'd7,
		ClsString  = 4'd8,
		ClsKeyword = 4'd9,
		ClsBadKw   = 4'd10,
		ClsUnknown = 4'd11
	} tok_class_t;

	typedef struct packed {
		tok_class_t  cls;
		logic [7:0]  len;
		logic [3:0]  kw;
	} res_t;

	// One queue entry: a result, optionally followed by an end-of-input record
	typedef struct packed {
		res_t  res;
		logic  eof_follow;
	} entry_t;

	localparam logic [KwMaxLen*8-1:0] KwStr [NumKw] = '{
		".character", ".code", ".constants", ".double", ".entry-point",
		".globals-count", ".int32", ".procedure", ".string", ".version"
	};
	localparam logic [7:0] KwLen [NumKw] = '{
		8'd10, 8'd5, 8'd10, 8'd7, 8'd12, 8'd14, 8'd6, 8'd10, 8'd7, 8'd8
	};

	// Character at position pos of keyword k (strings are right-justified)
	function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
		int sh;
		sh = int'(KwLen[k]) - 1 - int'(pos);
		if (sh < 0)
			return 8'h00;
		return KwStr[k][8*sh +: 8];
	endfunction

endpackage

[design/ats_front.sv]
// Front end of the token scanner: accepts characters, runs the scanning DFA,
// and pushes finished-token results into the result queue. Uses ats_pkg.
module ats_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         ch,
	input  logic               at_end,
	input  logic [7:0]         lim,
	input  logic               q_full,
	output logic               push,
	output ats_pkg::entry_t    push_entry
);

	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChQuote = 8'h22;
	localparam logic [7:0] ChHash  = 8'h23;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChDot   = 8'h2E;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChColon = 8'h3A;
	localparam logic [7:0] ChAt    = 8'h40;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpF   = 8'h46;
	localparam logic [7:0] ChUpZ   = 8'h5A;
	localparam logic [7:0] ChBslash= 8'h5C;
	localparam logic [7:0] ChLoA   = 8'h61;
	localparam logic [7:0] ChLoF   = 8'h66;
	localparam logic [7:0] ChLoX   = 8'h78;
	localparam logic [7:0] ChLoZ   = 8'h7A;

	typedef enum logic [3:0] {
		StSkip, StDec, StHex, StHexPre, StZero, StRealPre, StReal, StIdent,
		StLabLead, StLabDef, StStr, StStrEnd, StStrEsc, StKw, StBad
	} scan_state_t;

	scan_state_t                 state_q, state_d, nxt;
	logic [7:0]                  cnt_q, cnt_d;
	logic                        lab_q, lab_d;
	logic                        com_q, com_d;
	logic [ats_pkg::NumKw-1:0]   kwm_q, kwm_d, kw_hit;
	ats_pkg::res_t               pend_res;
	logic                        accept, tok;
	logic                        is_dig, is_low, is_alpha, is_xdig, is_sp, in_str;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign is_dig   = (ch >= ChZero) && (ch <= ChNine);
	assign is_low   = (ch >= ChLoA) && (ch <= ChLoZ);
	assign is_alpha = is_low || ((ch >= ChUpA) && (ch <= ChUpZ));
	assign is_xdig  = is_dig || ((ch >= ChLoA) && (ch <= ChLoF))
		|| ((ch >= ChUpA) && (ch <= ChUpF));
	assign is_sp    = (ch == ChSpace) || ((ch >= ChTab) && (ch <= ChCr));
	assign in_str   = (state_q == StStr) || (state_q == StStrEsc);

	// Per-keyword compare at the current position
	always_comb begin
		for (int k = 0; k < ats_pkg::NumKw; k++) begin
			kw_hit[k] = (cnt_q < ats_pkg::KwLen[k])
				&& (ats_pkg::kw_char(k, cnt_q[3:0]) == ch);
		end
	end

	// Class of the pending token
	always_comb begin
		logic found;
		found = 1'b0;
		pend_res.len = cnt_q;
		pend_res.kw  = 4'd0;
		pend_res.cls = ats_pkg::ClsUnknown;
		unique case (state_q)
			StIdent:        pend_res.cls = lab_q ? ats_pkg::ClsLabel : ats_pkg::ClsIdent;
			StZero, StDec:  pend_res.cls = ats_pkg::ClsDec;
			StHex:          pend_res.cls = ats_pkg::ClsHex;
			StReal:         pend_res.cls = ats_pkg::ClsReal;
			StLabDef:       pend_res.cls = ats_pkg::ClsLabDef;
			StStrEnd:       pend_res.cls = ats_pkg::ClsString;
			StKw: begin
				pend_res.cls = ats_pkg::ClsBadKw;
				for (int k = 0; k < ats_pkg::NumKw; k++) begin
					if (!found && kwm_q[k] && (ats_pkg::KwLen[k] == cnt_q)) begin
						found = 1'b1;
						pend_res.cls = ats_pkg::ClsKeyword;
						pend_res.kw  = 4'(k);
					end
				end
			end
			default:        pend_res.cls = ats_pkg::ClsUnknown;
		endcase
	end

	// DFA transition
	always_comb begin
		nxt = StBad;
		unique case (state_q)
			StSkip: begin
				priority if (is_alpha)                  nxt = StIdent;
				else if (ch == ChDot)                   nxt = StKw;
				else if (ch == ChZero)                  nxt = StZero;
				else if (is_dig || ch == ChMinus)       nxt = StDec;
				else if (ch == ChQuote)                 nxt = StStr;
				else if (ch == ChAt)                    nxt = StLabLead;
				else                                    nxt = StBad;
			end
			StIdent: begin
				priority if (is_alpha || is_dig || ch == ChMinus) nxt = StIdent;
				else if (!lab_q && ch == ChColon)                  nxt = StLabDef;
				else                                               nxt = StBad;
			end
			StZero: begin
				priority if (is_dig)       nxt = StDec;
				else if (ch == ChLoX)      nxt = StHexPre;
				else if (ch == ChDot)      nxt = StRealPre;
				else                       nxt = StBad;
			end
			StDec: begin
				priority if (ch == ChDot)  nxt = StRealPre;
				else if (is_dig)           nxt = StDec;
				else                       nxt = StBad;
			end
			StHexPre, StHex:    nxt = is_xdig ? StHex : StBad;
			StRealPre, StReal:  nxt = is_dig ? StReal : StBad;
			StKw:               nxt = (is_low || is_dig || ch == ChMinus) ? StKw : StBad;
			StLabLead:          nxt = is_alpha ? StIdent : StBad;
			StStr: begin
				priority if (ch == ChBslash) nxt = StStrEsc;
				else if (ch == ChQuote)      nxt = StStrEnd;
				else                         nxt = StStr;
			end
			StStrEsc:           nxt = StStr;
			default:            nxt = StBad;
		endcase
	end

	// Per-character step
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		lab_d   = lab_q;
		com_d   = com_q;
		kwm_d   = kwm_q;
		push    = 1'b0;
		push_entry = '0;
		tok     = 1'b0;
		if (accept) begin
			if (at_end) begin
				push = 1'b1;
				if (state_q != StSkip) begin
					push_entry.res        = pend_res;
					push_entry.eof_follow = 1'b1;
				end else begin
					push_entry.res.cls = ats_pkg::ClsEof;
				end
				com_d   = 1'b0;
				state_d = StSkip;
				cnt_d   = '0;
				lab_d   = 1'b0;
				kwm_d   = '1;
			end else begin
				tok = 1'b1;
				if (state_q == StSkip) begin
					if (com_q) begin
						tok = 1'b0;
						if (ch == ChLf)
							com_d = 1'b0;
					end else if (is_sp) begin
						tok = 1'b0;
					end else if (ch == ChHash) begin
						tok   = 1'b0;
						com_d = 1'b1;
					end
				end else if (!in_str && is_sp) begin
					tok            = 1'b0;
					push           = 1'b1;
					push_entry.res = pend_res;
					state_d = StSkip;
					cnt_d   = '0;
					lab_d   = 1'b0;
					kwm_d   = '1;
				end
				if (tok) begin
					if (cnt_q >= lim) begin
						push               = 1'b1;
						push_entry.res.cls = ats_pkg::ClsTooBig;
						push_entry.res.len = cnt_q;
						state_d = StSkip;
						cnt_d   = '0;
						lab_d   = 1'b0;
						kwm_d   = '1;
					end else if (state_q == StStr && ch == ChLf) begin
						push               = 1'b1;
						push_entry.res.cls = ats_pkg::ClsUnknown;
						push_entry.res.len = cnt_q;
						state_d = StSkip;
						cnt_d   = '0;
						lab_d   = 1'b0;
						kwm_d   = '1;
					end else begin
						kwm_d   = kwm_q & kw_hit;
						state_d = nxt;
						cnt_d   = cnt_q + 8'd1;
						if (state_q == StSkip && ch == ChAt)
							lab_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StSkip;
			cnt_q   <= '0;
			lab_q   <= 1'b0;
			com_q   <= 1'b0;
			kwm_q   <= '1;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			lab_q   <= lab_d;
			com_q   <= com_d;
			kwm_q   <= kwm_d;
		end
	end

	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StSkip) |-> (cnt_q == 8'd0 && kwm_q == '1 && !lab_q))
		else $error("skip state with leftover token state");

	a_comment_skip: assert property (@(posedge clk) disable iff (!arst_n)
		com_q |-> (state_q == StSkip))
		else $error("comment flag set inside a token");

endmodule

[design/ats_fifo.sv]
// Short result queue between the scanner front end and the output stage.
// Flop-based circular buffer of ats_pkg::entry_t. Uses ats_pkg.
module ats_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ats_pkg::entry_t     push_entry,
	input  logic                pop,
	output ats_pkg::entry_t     head,
	output logic                full,
	output logic                empty
);

	ats_pkg::entry_t                 mem_q [ats_pkg::FifoDepth];
	logic [ats_pkg::PtrW-1:0]        wr_q, rd_q;
	logic [ats_pkg::FifoCntW-1:0]    cnt_q;
	logic                            do_push, do_pop;

	localparam logic [ats_pkg::PtrW-1:0] LastPtr = ats_pkg::PtrW'(ats_pkg::FifoDepth - 1);
	localparam logic [ats_pkg::FifoCntW-1:0] FullCnt = ats_pkg::FifoCntW'(ats_pkg::FifoDepth);

	assign full    = (cnt_q == FullCnt);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == ats_pkg::FifoCntW'($past(cnt_q) + 1'b1)))
		else $error("queue fill count lost a push");

endmodule

[design/ats_back.sv]
// Output stage: takes queue entries and presents results on the master stream,
// expanding an entry that carries a trailing end-of-input record. Uses ats_pkg.
module ats_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  ats_pkg::entry_t    q_head,
	output logic               pop,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [15:0]        m_axis_tdata,  // [7:0] token_length, [11:8] keyword_index
	output logic [3:0]         m_axis_tuser,  // [3:0] token_class
	output logic               m_axis_tlast   // last
);

	ats_pkg::res_t  res_q;
	logic           valid_q, last_q, eof_pend_q;
	logic           free;

	// Register is free when empty, or when its result leaves with nothing owed behind it
	assign free = !valid_q || (m_axis_tready && !eof_pend_q);
	assign pop  = free && !q_empty;

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {4'd0, res_q.kw, res_q.len};
	assign m_axis_tuser  = res_q.cls;
	assign m_axis_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			eof_pend_q <= 1'b0;
			last_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			if (valid_q && m_axis_tready && eof_pend_q) begin
				res_q      <= '{cls: ats_pkg::ClsEof, len: 8'd0, kw: 4'd0};
				last_q     <= 1'b1;
				eof_pend_q <= 1'b0;
			end else if (pop) begin
				valid_q    <= 1'b1;
				res_q      <= q_head.res;
				last_q     <= !q_head.eof_follow;
				eof_pend_q <= q_head.eof_follow;
			end else if (free) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_eof_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast)
			|=> (m_axis_tvalid && m_axis_tlast && m_axis_tuser == ats_pkg::ClsEof))
		else $error("non-final result not followed by end-of-input record");

endmodule

[design/assembler_token_scanner_top.sv]
// Top level of the assembler token scanner.
// Instantiates ats_front, ats_fifo and ats_back; holds the token limit register. Uses ats_pkg.
//
// The block takes one character per transaction on the slave stream (tlast marks end of
// input) and reports each finished token on the master stream as class, length and keyword
// index. Whitespace and '#' comments between tokens are skipped without output. A token
// ends at whitespace (or at a newline inside an open string, which reports unknown); one
// longer than token_limit reports too_big and the offending character is dropped. An end
// of input flushes a pending token and then reports eof, so that transaction may yield two
// results, the second marked by tlast; every other result carries tlast too. Throughput is
// one character per clock: the scanner state is updated once per character,
// results pass through a four-entry queue and an output register, and the input side only
// stalls when that queue is full. A result is written into the queue and then into the
// output register, which presents it on the master stream and holds it until it is taken.
// token_limit may be written only while the block is idle; cfg_ready is always high.
module assembler_token_scanner_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] ch
	input  logic         s_axis_tlast,   // at_end
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [15:0]  m_axis_tdata,   // [7:0] token_length, [11:8] keyword_index
	output logic [3:0]   m_axis_tuser,   // [3:0] token_class
	output logic         m_axis_tlast,   // last
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data        // token_limit
);

	logic [7:0]        token_limit_q;
	logic [7:0]        lim;
	logic              push, pop, q_full, q_empty;
	ats_pkg::entry_t   push_entry, q_head;

	assign cfg_ready = 1'b1;

	// Clamp the limit to what the length field can report
	assign lim = (token_limit_q > ats_pkg::LimCap) ? ats_pkg::LimCap : token_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			token_limit_q <= 8'd255;
		else if (cfg_valid && cfg_ready)
			token_limit_q <= cfg_data;
	end

	// Scanner DFA: classifies characters and pushes finished tokens
	ats_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.ch         (s_axis_tdata),
		.at_end     (s_axis_tlast),
		.lim        (lim),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouple the scanner from downstream stalls
	ats_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (q_head),
		.full       (q_full),
		.empty      (q_empty)
	);

	// Present results, expanding the trailing eof record
	ats_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

[test/testbench.sv]
// Self-checking testbench for the assembler token scanner (assembler_token_scanner_top).
// Feeds character streams, predicts every token result in step with the stream and compares
// each output transaction with it. Needs ats_pkg and the scanner RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit      = 500000;
	localparam int ItemsPerPhase   = 70;

	typedef logic [7:0] char_t;

	// Scanner states, kept apart from the RTL's own encoding
	typedef enum int {
		ScSkip, ScDec, ScHex, ScHexPre, ScZero, ScRealPre, ScReal, ScIdent,
		ScLabLead, ScLabDef, ScStr, ScStrEnd, ScStrEsc, ScKw, ScBad
	} scan_t;

	typedef struct {
		ats_pkg::tok_class_t  cls;
		logic [7:0]           len;
		logic [3:0]           kw;
		bit                   last;
	} token_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [15:0]  m_axis_tdata;
	logic [3:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [7:0]   cfg_data;

	string kw_words [10] = '{
		".character", ".code", ".constants", ".double", ".entry-point",
		".globals-count", ".int32", ".procedure", ".string", ".version"
	};
	char_t space_chars [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

	// Predicted scanner state
	scan_t        sc_state;
	int           tok_len;
	bit           at_label;
	bit           str_open;
	bit           comment_open;
	logic [9:0]   kw_alive;
	logic [7:0]   limit_reg;

	token_t       tokens_due [$];
	token_t       next_due;
	char_t        token_text [$];

	int           send_idle_pct;
	int           stall_pct;
	int           rx_hold;
	int           error_count;
	int           cycle_count;
	int           sent_count;

	assembler_token_scanner_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- character classes

	function automatic bit is_digit(char_t c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_lower(char_t c);
		return c >= "a" && c <= "z";
	endfunction

	function automatic bit is_alpha(char_t c);
		return is_lower(c) || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_space(char_t c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	// ---------------------------------------------------------------- token predictor

	function automatic void restart_scan();
		sc_state = ScSkip;
		tok_len  = 0;
		at_label = 1'b0;
		str_open = 1'b0;
		kw_alive = '1;
	endfunction

	function automatic void push_token(ats_pkg::tok_class_t cls, int len, int kw, bit last);
		token_t t;
		t.cls  = cls;
		t.len  = 8'(len);
		t.kw   = 4'(kw);
		t.last = last;
		tokens_due.push_back(t);
	endfunction

	// Classify the pending token from the state it stopped in
	function automatic void finish_token(bit last);
		case (sc_state)
			ScIdent:
				push_token(at_label ? ats_pkg::ClsLabel : ats_pkg::ClsIdent,
					tok_len, 0, last);
			ScZero, ScDec: push_token(ats_pkg::ClsDec, tok_len, 0, last);
			ScHex:         push_token(ats_pkg::ClsHex, tok_len, 0, last);
			ScReal:        push_token(ats_pkg::ClsReal, tok_len, 0, last);
			ScLabDef:      push_token(ats_pkg::ClsLabDef, tok_len, 0, last);
			ScStrEnd:      push_token(ats_pkg::ClsString, tok_len, 0, last);
			ScKw: begin
				for (int k = 0; k < 10; k++) begin
					if (kw_alive[k] && kw_words[k].len() == tok_len) begin
						push_token(ats_pkg::ClsKeyword, tok_len, k, last);
						return;
					end
				end
				push_token(ats_pkg::ClsBadKw, tok_len, 0, last);
			end
			default:       push_token(ats_pkg::ClsUnknown, tok_len, 0, last);
		endcase
	endfunction

	function automatic scan_t next_scan(char_t c);
		case (sc_state)
			ScSkip: begin
				if (is_alpha(c))
					return ScIdent;
				if (c == ".")
					return ScKw;
				if (c == "0")
					return ScZero;
				if (is_digit(c) || c == "-")
					return ScDec;
				if (c == "\"") begin
					str_open = 1'b1;
					return ScStr;
				end
				if (c == "@") begin
					at_label = 1'b1;
					return ScLabLead;
				end
				return ScBad;
			end
			ScIdent: begin
				if (is_alpha(c) || is_digit(c) || c == "-")
					return ScIdent;
				if (!at_label && c == ":")
					return ScLabDef;
				return ScBad;
			end
			ScZero: begin
				if (is_digit(c))
					return ScDec;
				if (c == "x")
					return ScHexPre;
				if (c == ".")
					return ScRealPre;
				return ScBad;
			end
			ScDec: begin
				if (c == ".")
					return ScRealPre;
				return is_digit(c) ? ScDec : ScBad;
			end
			ScHexPre, ScHex: begin
				if (is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
					return ScHex;
				return ScBad;
			end
			ScRealPre, ScReal:
				return is_digit(c) ? ScReal : ScBad;
			ScKw:
				return (is_lower(c) || is_digit(c) || c == "-") ? ScKw : ScBad;
			ScLabLead:
				return is_alpha(c) ? ScIdent : ScBad;
			ScStr: begin
				if (c == "\\")
					return ScStrEsc;
				if (c == "\"") begin
					str_open = 1'b0;
					return ScStrEnd;
				end
				return ScStr;
			end
			ScStrEsc:
				return ScStr;
			default:
				return ScBad;
		endcase
	endfunction

	// Advance the predicted scanner by one accepted character and queue its results
	function automatic void predict_tokens(char_t c, bit eoi);
		if (eoi) begin
			if (sc_state != ScSkip)
				finish_token(1'b0);
			push_token(ats_pkg::ClsEof, 0, 0, 1'b1);
			comment_open = 1'b0;
			restart_scan();
			return;
		end
		if (sc_state == ScSkip) begin
			if (comment_open) begin
				if (c == 8'h0a)
					comment_open = 1'b0;
				return;
			end
			if (is_space(c))
				return;
			if (c == "#") begin
				comment_open = 1'b1;
				return;
			end
			restart_scan();
		end else if (!str_open && is_space(c)) begin
			finish_token(1'b1);
			restart_scan();
			return;
		end
		// the overflow check wins over a newline in an open string
		if (tok_len >= limit_reg) begin
			push_token(ats_pkg::ClsTooBig, tok_len, 0, 1'b1);
			restart_scan();
			return;
		end
		if (sc_state == ScStr && c == 8'h0a) begin
			push_token(ats_pkg::ClsUnknown, tok_len, 0, 1'b1);
			restart_scan();
			return;
		end
		for (int k = 0; k < 10; k++) begin
			if (tok_len >= kw_words[k].len() || char_t'(kw_words[k][tok_len]) != c)
				kw_alive[k] = 1'b0;
		end
		sc_state = next_scan(c);
		tok_len++;
	endfunction

	// ---------------------------------------------------------------- drivers

	// Offer one character (or an end mark) and hold it until the scanner takes it
	task automatic send_char(input char_t c, input bit eoi);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= eoi;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sent_count++;
		predict_tokens(c, eoi);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(char_t'(s[i]), 1'b0);
	endtask

	task automatic send_end();
		send_char(char_t'($urandom_range(0, 255)), 1'b1);
	endtask

	// Drop the stream and hold until every predicted result has been seen, then let the
	// scanner settle
	task automatic wait_quiet();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		limit_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: honour a long hold-off first, otherwise stall at random
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Compare every output transaction with the oldest predicted token
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (tokens_due.size() == 0) begin
				$error("unexpected result: token_class %0d, token_length %0d",
					m_axis_tuser, m_axis_tdata[7:0]);
				error_count++;
			end else begin
				next_due = tokens_due.pop_front();
				if (m_axis_tuser !== next_due.cls) begin
					$error("token_class: expected %0d, got %0d", next_due.cls, m_axis_tuser);
					error_count++;
				end
				if (m_axis_tdata[7:0] !== next_due.len) begin
					$error("token_length: expected %0d, got %0d",
						next_due.len, m_axis_tdata[7:0]);
					error_count++;
				end
				if (m_axis_tdata[11:8] !== next_due.kw) begin
					$error("keyword_index: expected %0d, got %0d",
						next_due.kw, m_axis_tdata[11:8]);
					error_count++;
				end
				if (m_axis_tlast !== next_due.last) begin
					$error("last: expected %0d, got %0d", next_due.last, m_axis_tlast);
					error_count++;
				end
			end
		end
	end

	// Guard against a hung scanner
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------- random stream

	function automatic char_t pick(input string set);
		return char_t'(set[$urandom_range(0, set.len() - 1)]);
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			token_text.push_back(char_t'(s[i]));
	endfunction

	// Build one token, mostly well formed with random content, some broken, some noise
	function automatic void make_token(input bit force_long);
		int kind;
		int k;
		int r;
		token_text.delete();
		kind = force_long ? 99 : $urandom_range(0, 99);
		if (kind < 10) begin
			if ($urandom_range(0, 3) == 0)
				token_text.push_back("-");
			repeat ($urandom_range(1, 5))
				token_text.push_back(pick("0123456789"));
		end else if (kind < 18) begin
			push_text("0x");
			repeat ($urandom_range(0, 5))
				token_text.push_back(pick("0123456789abcdefABCDEFg"));
		end else if (kind < 26) begin
			token_text.push_back(pick("0123456789"));
			repeat ($urandom_range(0, 2))
				token_text.push_back(pick("0123456789"));
			token_text.push_back(".");
			repeat ($urandom_range(0, 3))
				token_text.push_back(pick("0123456789."));
		end else if (kind < 52) begin
			// identifiers, labels and label definitions
			if (kind >= 38 && kind < 45)
				token_text.push_back("@");
			if ($urandom_range(0, 9) != 0)
				token_text.push_back(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
			else
				token_text.push_back(pick("0-_:"));
			repeat ($urandom_range(0, 7))
				token_text.push_back(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-"));
			if (kind >= 45)
				token_text.push_back(":");
			if (kind >= 38 && $urandom_range(0, 4) == 0)
				token_text.push_back(pick("a:0#"));
		end else if (kind < 64) begin
			token_text.push_back("\"");
			repeat ($urandom_range(0, 8)) begin
				r = $urandom_range(0, 9);
				if (r == 0) begin
					token_text.push_back("\\");
					token_text.push_back(char_t'($urandom_range(0, 255)));
				end else if (r == 1) begin
					token_text.push_back(pick(" #"));
				end else begin
					token_text.push_back(char_t'($urandom_range(32, 126)));
				end
			end
			r = $urandom_range(0, 9);
			if (r < 8)
				token_text.push_back("\"");
			else if (r == 8)
				token_text.push_back(8'h0a);
		end else if (kind < 76) begin
			k = $urandom_range(0, 9);
			push_text(kw_words[k]);
			r = $urandom_range(0, 7);
			if (r == 0)
				void'(token_text.pop_back());
			else if (r == 1)
				token_text.push_back(pick("az0-"));
		end else if (kind < 82) begin
			token_text.push_back(".");
			repeat ($urandom_range(0, 6))
				token_text.push_back(pick("abcdefghijklmnopqrstuvwxyz0-"));
		end else if (kind < 98) begin
			repeat ($urandom_range(1, 4))
				token_text.push_back(char_t'($urandom_range(0, 255)));
		end else begin
			// long run to reach the largest lengths and the limit
			repeat (force_long ? 256 : $urandom_range(250, 260))
				token_text.push_back(pick("abcdefghijklmnopqrstuvwxyz"));
		end
	endfunction

	task automatic send_separator();
		char_t c;
		if ($urandom_range(0, 99) < 8) begin
			send_char("#", 1'b0);
			repeat ($urandom_range(0, 6)) begin
				c = char_t'($urandom_range(0, 255));
				send_char((c == 8'h0a) ? 8'h0b : c, 1'b0);
			end
			send_char(8'h0a, 1'b0);
		end
		repeat ($urandom_range(1, 3))
			send_char(space_chars[$urandom_range(0, 5)], 1'b0);
	endtask

	// ---------------------------------------------------------------- tests

	// Every class but too_big, keyword hit and miss, escapes, comments, high bytes and end marks
	task automatic test_token_classes();
		write_limit(8'd255);
		send_text("0x1F 7 -3 0.5 00 0x ab @c d: @e: \"a b\\\"\\\n#\" ");
		send_text(".code .cod .codes . 0# 1.2.3 #note ");
		send_char(8'hff, 1'b0);
		send_text("\n");
		send_char(8'h80, 1'b0);
		send_text(" \"x\ny q");
		// flush a pending token, then a bare end mark
		send_end();
		send_end();
		send_text("\"open");
		send_end();
		send_text("#c");
		send_end();
		wait_quiet();
	endtask

	// Overflow at small limits, the zero limit, and overflow inside a string
	task automatic test_token_limit();
		write_limit(8'd3);
		send_text("abc abcd \"ab\nxy ");
		wait_quiet();
		write_limit(8'd0);
		send_text("x 5 ");
		wait_quiet();
		write_limit(8'd1);
		send_text("5 56 ");
		wait_quiet();
	endtask

	// Hold the receiver off so the result queue fills and the input stalls
	task automatic test_backpressure();
		write_limit(8'd255);
		rx_hold = 200;
		repeat (20)
			send_text("7 ");
		wait_quiet();
	endtask

	task automatic test_random_stream();
		int first;
		logic [7:0] limits [4] = '{8'd255, 8'd12, 8'd4, 8'd255};
		int idle_pcts [4] = '{0, 67, 0, 21};
		int stall_pcts [4] = '{0, 0, 67, 21};
		for (int phase = 0; phase < 4; phase++) begin
			wait_quiet();
			write_limit(limits[phase]);
			send_idle_pct = idle_pcts[phase];
			stall_pct     = stall_pcts[phase];
			first = sent_count;
			while (sent_count - first < ItemsPerPhase) begin
				make_token(phase == 0 && sent_count == first);
				foreach (token_text[i])
					send_char(token_text[i], 1'b0);
				if ($urandom_range(0, 99) < 4)
					send_end();
				else
					send_separator();
				// now and then pause until every result is back
				if ($urandom_range(0, 99) < 2)
					wait_quiet();
			end
			send_end();
		end
		wait_quiet();
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		rx_hold       = 0;
		error_count   = 0;
		cycle_count   = 0;
		sent_count    = 0;
		limit_reg     = 8'd255;
		comment_open  = 1'b0;
		restart_scan();

		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_token_classes();
		test_token_limit();
		test_backpressure();
		test_random_stream();

		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
